// ===== src/sond_pkg.sv =====
// Package for the serial-order node dynamics core: payload types, constants
// and register indexes. No dependencies.
package sond_pkg;

    localparam int unsigned POSITIONS_DEF = 4;
    localparam int unsigned CFG_REGS = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned ACT_W = 24;
    localparam int unsigned OUT_W = 17;

    localparam logic signed [ACT_W-1:0] MEM_INHIB_W = -24'sd131072;
    localparam logic signed [ACT_W-1:0] ORD_TO_MEM_W = 24'sd458752;
    localparam logic [OUT_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic signed [ACT_W-1:0] ACT_MAX = 24'sh7FFFFF;
    localparam logic signed [ACT_W-1:0] ACT_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAU         = 3'd0,
        REG_ORD_REST    = 3'd1,
        REG_ORD_SELF    = 3'd2,
        REG_ORD_INHIB   = 3'd3,
        REG_MEM_TO_NEXT = 3'd4,
        REG_MEM_TO_SAME = 3'd5,
        REG_MEM_REST    = 3'd6,
        REG_MEM_SELF    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic              func;
        logic [19:0]       step_us;
        logic signed [23:0] cos_signal;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         position;
        logic signed [23:0] ordinal_activation;
        logic [16:0]        ordinal_output;
        logic signed [23:0] memory_activation;
        logic [16:0]        memory_output;
        logic               last;
    } out_item_t;

    // weights and levels a cell needs for its update
    typedef struct packed {
        logic signed [23:0] ord_rest;
        logic signed [23:0] ord_self;
        logic signed [23:0] ord_inhib;
        logic signed [23:0] mem_to_next;
        logic signed [23:0] mem_to_same;
        logic signed [23:0] mem_rest;
        logic signed [23:0] mem_self;
    } weights_t;

endpackage

// ===== src/sond_cell.sv =====
// One position cell: holds an ordinal and a memory activation, rotates them
// to its neighbor on shift. Depends on sond_pkg.
module sond_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      shift,
    input  logic signed [23:0]        ord_load,
    input  logic signed [23:0]        mem_load,
    input  logic signed [23:0]        ord_in,
    input  logic signed [23:0]        mem_in,
    output logic signed [23:0]        ord_out,
    output logic signed [23:0]        mem_out
);
    import sond_pkg::*;

    logic signed [ACT_W-1:0] ord_reg, mem_reg;

    // reset level, bulk load, or rotate one place along the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_reg <= -24'sd327680;
            mem_reg <= -24'sd131072;
        end
        else if (load)
        begin
            ord_reg <= ord_load;
            mem_reg <= mem_load;
        end
        else if (shift)
        begin
            ord_reg <= ord_in;
            mem_reg <= mem_in;
        end
    end

    assign ord_out = ord_reg;
    assign mem_out = mem_reg;
endmodule

// ===== src/sond_div.sv =====
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a
// cycle. Depends on sond_pkg.
module sond_div #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import sond_pkg::*;

    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    // shift one numerator bit into the remainder each cycle; done follows
    // the final step so the quotient is complete when it is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ===== src/serial_order_node_dynamics_step_core.sv =====
// Top level of the serial-order node dynamics core: config registers, cell
// row, sequencer and shared divider. Depends on sond_pkg, sond_cell, sond_div.
//
// Use: an input beat (func, step_us, cos_signal) is taken on in_valid while
// in_stall is low. A step beat (func 0) produces POSITIONS output beats, one
// per position from 0 upward, last set on the final one. A reset beat
// (func 1) reloads the resting levels and produces nothing.
// Cells rotate their activations through a single shared compute port: the
// first sweep takes the sigmoid of each of the 2*POSITIONS values, the
// second computes the two Euler steps of each position. Each sigmoid and
// each increment is one pass of a 48-step serial divider. A step beat holds
// in_stall high until its last output beat is taken; a reset beat holds it
// for one cycle. The block takes one beat at a time. When out_stall is high
// the held output beat waits, and the sequence pauses when it reaches its
// next output beat.
// After reset all nodes sit at the reset resting levels and the
// configuration registers hold their reset values.
// Config writes belong in idle time and take effect on the next beat.
module serial_order_node_dynamics_step_core
    import sond_pkg::*;
#(
    parameter int unsigned POSITIONS = POSITIONS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  sond_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output sond_pkg::out_item_t       out_data,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [23:0]               cfg_wdata
);
    localparam int unsigned PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int unsigned NW = 48;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SIGA  = 10'b0000000010,
        S_SIGW  = 10'b0000000100,
        S_RATE  = 10'b0000001000,
        S_RMUL  = 10'b0000010000,
        S_ODIV  = 10'b0000100000,
        S_MDIV  = 10'b0001000000,
        S_EMIT  = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_RST   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // ---------------- configuration registers
    logic [15:0] tau_reg;
    weights_t    w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg           <= 16'd100;
            w_reg.ord_rest    <= -24'sd327680;
            w_reg.ord_self    <= 24'sd393216;
            w_reg.ord_inhib   <= -24'sd720896;
            w_reg.mem_to_next <= 24'sd327680;
            w_reg.mem_to_same <= -24'sd327680;
            w_reg.mem_rest    <= -24'sd131072;
            w_reg.mem_self    <= 24'sd458752;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TAU:         tau_reg           <= cfg_wdata[15:0];
                REG_ORD_REST:    w_reg.ord_rest    <= cfg_wdata;
                REG_ORD_SELF:    w_reg.ord_self    <= cfg_wdata;
                REG_ORD_INHIB:   w_reg.ord_inhib   <= cfg_wdata;
                REG_MEM_TO_NEXT: w_reg.mem_to_next <= cfg_wdata;
                REG_MEM_TO_SAME: w_reg.mem_to_same <= cfg_wdata;
                REG_MEM_REST:    w_reg.mem_rest    <= cfg_wdata;
                REG_MEM_SELF:    w_reg.mem_self    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- cell row; cell 0 is the head and feeds back into cell P-1
    logic signed [23:0] ord_q [POSITIONS];
    logic signed [23:0] mem_q [POSITIONS];
    logic signed [23:0] head_ord_in, head_mem_in;
    logic               row_load, row_shift;

    for (genvar g = 0; g < POSITIONS; g++)
    begin : g_cell
        if (g == POSITIONS - 1)
        begin : g_tail
            sond_cell u_cell (
                .clk(clk), .rst_n(rst_n), .load(row_load), .shift(row_shift),
                .ord_load(w_reg.ord_rest), .mem_load(w_reg.mem_rest),
                .ord_in(head_ord_in), .mem_in(head_mem_in),
                .ord_out(ord_q[g]), .mem_out(mem_q[g]));
        end
        else
        begin : g_mid
            sond_cell u_cell (
                .clk(clk), .rst_n(rst_n), .load(row_load), .shift(row_shift),
                .ord_load(w_reg.ord_rest), .mem_load(w_reg.mem_rest),
                .ord_in(ord_q[g+1]), .mem_in(mem_q[g+1]),
                .ord_out(ord_q[g]), .mem_out(mem_q[g]));
        end
    end

    // sigmoid outputs, one shift line per node kind
    logic [16:0] fo_reg [POSITIONS];
    logic [16:0] fm_reg [POSITIONS];
    logic [19:0] sum_reg;

    // ---------------- working registers
    in_item_t           item_reg;
    logic [PW-1:0]      pos_reg;
    logic               half_reg;   // 0: ordinal value, 1: memory value
    logic [16:0]        fm_prev_reg;
    logic signed [23:0] nd_reg;
    logic signed [23:0] new_sat_m_reg;
    logic signed [55:0] acc_reg;
    logic [16:0]        fo_cur_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    // ---------------- divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_den, div_quo;
    logic          neg_reg;

    sond_div #(.NW(NW), .DW(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo));

    // sigmoid operand: head value of the current half
    logic signed [23:0] sx;
    logic [23:0]        sa;
    assign sx = half_reg ? mem_q[0] : ord_q[0];
    assign sa = sx[23] ? 24'(-sx) : sx;

    logic [47:0] sig_num, sig_den;
    // 2*num+den over 2*den: num = 3276800*a, den = 65536+100*a
    assign sig_den = 48'(2) * (48'd65536 + 48'(sa) * 48'd100);
    assign sig_num = 48'(sa) * 48'd6553600 + sig_den / 48'd2;

    logic [16:0] sig_q;
    assign sig_q = neg_reg ? 17'(HALF_Q16 - 17'(div_quo)) : 17'(HALF_Q16 + 17'(div_quo));

    // rate pieces for the position at the head
    logic [16:0] fo0, fm0;
    assign fo0 = fo_reg[0];
    assign fm0 = fm_reg[0];

    logic signed [55:0] acc_o, acc_m, acc_sel;
    logic [30:0]        rate_mag;
    logic [55:0]        acc_mag;
    always_comb
    begin
        acc_o = (56'(w_reg.ord_rest) - 56'(ord_q[0]) - 56'(item_reg.cos_signal)) * 56'sd65536
              + 56'(w_reg.ord_self) * $signed({39'd0, fo0})
              + 56'(w_reg.ord_inhib) * $signed({36'd0, sum_reg} - {39'd0, fo0})
              + 56'(w_reg.mem_to_same) * $signed({39'd0, fm0})
              + ((pos_reg == '0) ? 56'(w_reg.mem_to_next) * 56'sd65536
                                 : 56'(w_reg.mem_to_next) * $signed({39'd0, fm_prev_reg}));
        acc_m = (56'(w_reg.mem_rest) - 56'(mem_q[0])) * 56'sd65536
              + 56'(w_reg.mem_self) * $signed({39'd0, fm0})
              + 56'(MEM_INHIB_W) * $signed({36'd0, sum_reg} - {39'd0, fm0})
              + 56'(ORD_TO_MEM_W) * $signed({39'd0, fo0});
        acc_sel = half_reg ? acc_m : acc_o;
        acc_mag = acc_reg[55] ? 56'(-acc_reg) : 56'(acc_reg);
        // rate magnitude, rounded half away from zero; sign kept in acc_reg
        rate_mag = 31'((acc_mag + 56'd32768) >> 16);
    end

    // increment division: |rate*step| plus half the divisor, over tau*1000
    logic [15:0]        tau_eff;
    logic [47:0]        div_incr;
    logic [47:0]        inc_num;
    assign tau_eff  = (tau_reg == '0) ? 16'd1 : tau_reg;
    assign div_incr = 48'(tau_eff) * 48'd1000;
    assign inc_num  = 48'(rate_mag) * 48'(item_reg.step_us) + 48'(tau_eff) * 48'd500;

    logic signed [47:0] incr;
    logic signed [25:0] new_sum;
    logic signed [23:0] new_sat, base_act;
    always_comb
    begin
        incr = neg_reg ? -$signed(div_quo) : $signed(div_quo);
        base_act = half_reg ? mem_q[0] : ord_q[0];
        new_sum = 26'(base_act) + 26'(incr);
        if (incr > 48'sd16777216)
            new_sat = ACT_MAX;
        else if (incr < -48'sd16777216)
            new_sat = ACT_MIN;
        else if (new_sum > 26'(ACT_MAX))
            new_sat = ACT_MAX;
        else if (new_sum < 26'(ACT_MIN))
            new_sat = ACT_MIN;
        else
            new_sat = 24'(new_sum);
    end

    logic last_pos;
    assign last_pos = (pos_reg == PW'(POSITIONS - 1));

    // ---------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = sig_num;
        div_den    = sig_den;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = in_data.func ? S_RST : S_SIGA;
            S_RST:
                state_next = S_IDLE;
            S_SIGA:
            begin
                div_start  = 1'b1;
                state_next = S_SIGW;
            end
            S_SIGW:
                if (div_done)
                    state_next = (half_reg && last_pos) ? S_RATE : S_SIGA;
            S_RATE:
                state_next = S_RMUL;
            S_RMUL:
            begin
                div_start  = 1'b1;
                div_num    = inc_num;
                div_den    = div_incr;
                state_next = half_reg ? S_MDIV : S_ODIV;
            end
            S_ODIV:
                if (div_done)
                    state_next = S_RATE;
            S_MDIV:
                if (div_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (!out_valid_reg || !out_stall)
                    state_next = last_pos ? S_WAIT : S_RATE;
            S_WAIT:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign row_load  = (state_reg == S_RST);
    // rotate after both sigmoids of a position, or after emitting it
    assign row_shift = ((state_reg == S_SIGW) && div_done && half_reg)
                     || ((state_reg == S_EMIT) && (!out_valid_reg || !out_stall));

    assign head_ord_in = (state_reg == S_EMIT) ? nd_reg : ord_q[0];
    assign head_mem_in = (state_reg == S_EMIT) ? new_sat_m_reg : mem_q[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if ((state_reg == S_EMIT) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg <= in_data;
                pos_reg  <= '0;
                half_reg <= 1'b0;
                sum_reg  <= '0;
            end
            S_SIGA:
                neg_reg <= sx[23];
            S_SIGW:
                if (div_done)
                begin
                    if (!half_reg)
                    begin
                        fo_cur_reg <= sig_q;
                        sum_reg    <= sum_reg + 20'(sig_q);
                        half_reg   <= 1'b1;
                    end
                    else
                    begin
                        // sigmoid lines shift with the row
                        for (int k = 0; k < POSITIONS - 1; k++)
                        begin
                            fo_reg[k] <= fo_reg[k+1];
                            fm_reg[k] <= fm_reg[k+1];
                        end
                        fo_reg[POSITIONS-1] <= fo_cur_reg;
                        fm_reg[POSITIONS-1] <= sig_q;
                        half_reg <= 1'b0;
                        pos_reg  <= last_pos ? '0 : pos_reg + 1'b1;
                    end
                end
            S_RATE:
                acc_reg <= acc_sel;
            S_RMUL:
                neg_reg <= acc_reg[55];
            S_ODIV:
                if (div_done)
                begin
                    nd_reg   <= new_sat;
                    half_reg <= 1'b1;
                end
            S_MDIV:
                if (div_done)
                    new_sat_m_reg <= new_sat;
            S_EMIT:
                if (!out_valid_reg || !out_stall)
                begin
                    out_reg.position           <= 4'(pos_reg);
                    out_reg.ordinal_activation <= nd_reg;
                    out_reg.ordinal_output     <= fo0;
                    out_reg.memory_activation  <= new_sat_m_reg;
                    out_reg.memory_output      <= fm0;
                    out_reg.last               <= last_pos;
                    fm_prev_reg                <= fm0;
                    for (int k = 0; k < POSITIONS - 1; k++)
                    begin
                        fo_reg[k] <= fo_reg[k+1];
                        fm_reg[k] <= fm_reg[k+1];
                    end
                    fo_reg[POSITIONS-1] <= fo0;
                    fm_reg[POSITIONS-1] <= fm0;
                    half_reg <= 1'b0;
                    pos_reg  <= last_pos ? '0 : pos_reg + 1'b1;
                end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== src/sond_checker.sv =====
// Port-level checker for the serial-order node dynamics core, with its bind.
// Depends on sond_pkg.
module sond_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input sond_pkg::out_item_t  out_data,
    input logic                 out_valid,
    input logic                 out_stall
);
    import sond_pkg::*;

    // an output beat held under stall keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // results only appear while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("output beat without item in work");

    // more beats of the same item follow a non-last beat, input stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> in_stall)
        else $error("input opened before the last beat");

    // the last beat is still part of the item in work
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> in_stall)
        else $error("last beat outside item");

    // an accepted input beat closes the input in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input beat not followed by busy");
endmodule

bind serial_order_node_dynamics_step_core sond_checker u_sond_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall));
